// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, quiet during reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/kfls_pkg.sv =====
// Shared types and constants of the keyframe linear sampler.
package kfls_pkg;
   localparam int TIME_W  = 32;
   localparam int VAL_W   = 32;
   localparam int SEG_W   = 6;
   localparam int COUNT_W = 7;

   typedef enum logic [0:0] {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   // Controller -> datapath commands.
   typedef struct packed {
      logic write_key;   // store the request word
      logic latch_time;  // capture sample time
      logic rd_first;    // read slot 0
      logic rd_last;     // read slot count-1
      logic chk_first;   // compare time to key 0
      logic div_start;   // load divider
      logic div_step;    // one quotient bit
      logic mul_step;    // multiply one component
      logic load_held;   // take held value as result
      logic idx_inc;     // advance scan index
      logic idx_clr;     // clear scan index
   } kfls_cmd_type;

   // Datapath -> controller status.
   typedef struct packed {
      logic single;      // one key in use
      logic early;       // time at or before first key
      logic hit;         // time inside current segment
      logic scan_end;    // current segment is the last one
      logic div_done;    // quotient complete
      logic mul_done;    // all three components done
   } kfls_sts_type;
endpackage

// ===== rtl/core/keyframe_linear_sampler_core.sv =====
// Writes are stored from idle; samples read key 0, scan, divide and multiply, or hold an end key.
// The slot scan reads, then checks, each segment in turn; a hit starts the serial divider.
// One word at a time: the next word waits for the result to drain.
// Reset: synchronous, active high; key_count returns to 1, table is not cleared.
// Key table content is undefined until each slot is written.
module keyframe_linear_sampler_core #(
   parameter int MAX_KEYS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [5:0]  req_key_index,
   input  logic [31:0] req_key_time,
   input  logic signed [31:0] req_key_x,
   input  logic signed [31:0] req_key_y,
   input  logic signed [31:0] req_key_z,
   input  logic [31:0] req_sample_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [5:0]  rsp_segment,
   output logic        rsp_held,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_key_count
);
   import kfls_pkg::*;

   kfls_cmd_type cmd;
   kfls_sts_type sts;

   // Controller: sequence one word through scan, divide and multiply.
   kfls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (cmd_type'(req_cmd)),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: hold the key table and the arithmetic.
   kfls_datapath #(
      .MAX_KEYS  (MAX_KEYS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_write       (csr_valid && csr_ready),
      .csr_data        (csr_key_count),
      .req_key_index   (req_key_index),
      .req_key_time    (req_key_time),
      .req_key_x       (req_key_x),
      .req_key_y       (req_key_y),
      .req_key_z       (req_key_z),
      .req_sample_time (req_sample_time),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_segment     (rsp_segment),
      .rsp_held        (rsp_held)
   );
endmodule

// ===== rtl/core/kfls_ctrl.sv =====
// Controller state machine of the keyframe linear sampler.
module kfls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kfls_pkg::cmd_type     req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  csr_ready,
   output kfls_pkg::kfls_cmd_type cmd,
   input  kfls_pkg::kfls_sts_type sts
);
   import kfls_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RD0   = 9'b000000010,
      S_CHK0  = 9'b000000100,
      S_RDSEG = 9'b000001000,
      S_CHK   = 9'b000010000,
      S_DIV   = 9'b000100000,
      S_MUL   = 9'b001000000,
      S_RDL   = 9'b010000000,
      S_HOLD  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      done;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.idx_clr = 1'b1;
            if (req_valid && req_ready) begin
               if (req_cmd == CMD_WRITE) begin
                  cmd.write_key = 1'b1;
               end else begin
                  cmd.latch_time = 1'b1;
                  state_in = S_RD0;
               end
            end
         end
         S_RD0: begin
            cmd.rd_first = 1'b1;
            state_in = S_CHK0;
         end
         S_CHK0: begin
            cmd.chk_first = 1'b1;
            if (sts.single || sts.early) begin
               cmd.load_held = 1'b1;
               done = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RDSEG;
            end
         end
         S_RDSEG: begin
            // wait for the pair read at the scan index
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.hit) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else if (sts.scan_end) begin
               state_in = S_RDL;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = S_RDSEG;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_done) begin
               done = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RDL: begin
            cmd.rd_last = 1'b1;
            state_in = S_HOLD;
         end
         S_HOLD: begin
            cmd.load_held = 1'b1;
            done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (done) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== rtl/core/kfls_datapath.sv =====
// Key table, segment scan, serial divider and multiplier of the sampler.
module kfls_datapath #(
   parameter int MAX_KEYS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kfls_pkg::kfls_cmd_type        cmd,
   output kfls_pkg::kfls_sts_type        sts,
   input  logic                          csr_write,
   input  logic [kfls_pkg::COUNT_W-1:0]  csr_data,
   input  logic [kfls_pkg::SEG_W-1:0]    req_key_index,
   input  logic [kfls_pkg::TIME_W-1:0]   req_key_time,
   input  logic signed [kfls_pkg::VAL_W-1:0] req_key_x,
   input  logic signed [kfls_pkg::VAL_W-1:0] req_key_y,
   input  logic signed [kfls_pkg::VAL_W-1:0] req_key_z,
   input  logic [kfls_pkg::TIME_W-1:0]   req_sample_time,
   output logic signed [kfls_pkg::VAL_W-1:0] rsp_out_x,
   output logic signed [kfls_pkg::VAL_W-1:0] rsp_out_y,
   output logic signed [kfls_pkg::VAL_W-1:0] rsp_out_z,
   output logic [kfls_pkg::SEG_W-1:0]    rsp_segment,
   output logic                          rsp_held
);
   import kfls_pkg::*;

   localparam int IDX_W  = $clog2(MAX_KEYS);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int NUM_W  = TIME_W + FRAC_BITS;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int STEP_W = $clog2(NUM_W + 1);
   localparam int ROW_W  = TIME_W + 3 * VAL_W;

   // Key table: one row holds time and vector, two read ports.
   logic [ROW_W-1:0] mem [MAX_KEYS];
   logic [ROW_W-1:0] rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0] addr_a, addr_b;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]    n_keys;
   logic [IDX_W-1:0]    last_idx;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [TIME_W-1:0]   time_ff;

   always_comb begin
      if (count_ff == '0) n_keys = CNT_W'(1);
      else if (32'(count_ff) > MAX_KEYS) n_keys = CNT_W'(MAX_KEYS);
      else n_keys = CNT_W'(count_ff);
   end
   assign last_idx = IDX_W'(n_keys - CNT_W'(1));

   always_comb begin
      count_in = csr_write ? csr_data : count_ff;
      idx_in   = idx_ff;
      if (cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      addr_a = idx_ff;
      addr_b = idx_ff + IDX_W'(1);
      if (cmd.rd_first) addr_a = '0;
      if (cmd.rd_last)  addr_a = last_idx;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_key && (32'(req_key_index) < MAX_KEYS)) begin
         mem[IDX_W'(req_key_index)] <= {req_key_time, req_key_x, req_key_y, req_key_z};
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_time) time_ff <= req_sample_time;
   end

   logic [TIME_W-1:0] t0, t1;
   assign t0 = rd_a_ff[ROW_W-1 -: TIME_W];
   assign t1 = rd_b_ff[ROW_W-1 -: TIME_W];

   // Restoring divider: one quotient bit a cycle.
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [TIME_W:0]     rem_ff, rem_in, rem_sh;
   logic [TIME_W-1:0]   den_ff;
   logic [Q_W-1:0]      quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   // Multiplier: one component a cycle, result shifts through a row.
   logic [1:0]                 comp_ff, comp_in;
   logic [3*VAL_W-1:0]         a_ff, b_ff;
   logic signed [VAL_W-1:0]    res_ff [3];
   logic signed [VAL_W-1:0]    ca, cb, blend;
   logic signed [VAL_W:0]      diff;
   logic [VAL_W:0]             mag;
   logic [VAL_W+Q_W:0]         prod;
   logic [VAL_W:0]             scaled;
   logic [SEG_W-1:0]           seg_ff;
   logic                       held_ff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      rem_sh  = {rem_ff[TIME_W-1:0], num_ff[NUM_W-1]};
      if (cmd.div_start) begin
         num_in  = {time_ff - t0, FRAC_BITS'(0)};
         rem_in  = '0;
         quo_in  = '0;
         step_in = '0;
      end else if (cmd.div_step && (step_ff != STEP_W'(NUM_W))) begin
         num_in  = num_ff << 1;
         step_in = step_ff + STEP_W'(1);
         if (den_ff != '0 && rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         comp_ff <= '0;
      end else begin
         step_ff <= step_in;
         comp_ff <= comp_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= (cmd.div_step && den_ff == '0) ? '0 : quo_in;
      if (cmd.div_start) begin
         den_ff <= t1 - t0;
      end
   end

   always_comb begin
      ca     = a_ff[3*VAL_W-1 -: VAL_W];
      cb     = b_ff[3*VAL_W-1 -: VAL_W];
      diff   = {cb[VAL_W-1], cb} - {ca[VAL_W-1], ca};
      mag    = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
      prod   = (VAL_W+Q_W+1)'(mag) * (VAL_W+Q_W+1)'(quo_ff);
      scaled = (VAL_W+1)'(prod >> FRAC_BITS);
      blend  = diff[VAL_W] ? VAL_W'(ca - VAL_W'(scaled)) : VAL_W'(ca + VAL_W'(scaled));
      comp_in = comp_ff;
      if (cmd.mul_step) comp_in = sts.mul_done ? 2'd0 : comp_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
         res_ff[2] <= blend;
         a_ff      <= a_ff << VAL_W;
         b_ff      <= b_ff << VAL_W;
         held_ff   <= 1'b0;
      end else if (cmd.load_held) begin
         res_ff[0] <= rd_a_ff[3*VAL_W-1 -: VAL_W];
         res_ff[1] <= rd_a_ff[2*VAL_W-1 -: VAL_W];
         res_ff[2] <= rd_a_ff[VAL_W-1:0];
         seg_ff    <= cmd.chk_first ? '0 : SEG_W'(last_idx);
         held_ff   <= 1'b1;
      end else if (cmd.div_start) begin
         a_ff   <= rd_a_ff[3*VAL_W-1:0];
         b_ff   <= rd_b_ff[3*VAL_W-1:0];
         seg_ff <= SEG_W'(idx_ff);
      end
   end

   assign sts.single   = (n_keys == CNT_W'(1));
   assign sts.early    = (time_ff <= t0);
   assign sts.hit      = (t0 <= time_ff) && (time_ff <= t1);
   assign sts.scan_end = (CNT_W'(idx_ff) + CNT_W'(2) >= n_keys);
   assign sts.div_done = (step_ff == STEP_W'(NUM_W));
   assign sts.mul_done = (comp_ff == 2'd2);

   assign rsp_out_x   = res_ff[0];
   assign rsp_out_y   = res_ff[1];
   assign rsp_out_z   = res_ff[2];
   assign rsp_segment = seg_ff;
   assign rsp_held    = held_ff;
endmodule

// ===== rtl/core/kfls_checker.sv =====
// Port-level checker of the sampler, bound to the top level.
`include "assert_macros.svh"
module kfls_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_cmd,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_x
);
   `ASSERT_IMPL(a_no_take_while_out, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_write_no_rsp, clock, reset, req_valid && req_ready && !req_cmd, !rsp_valid)
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_x))
   `ASSERT_NEXT(a_sample_busy, clock, reset, req_valid && req_ready && req_cmd, !req_ready)
endmodule

bind keyframe_linear_sampler_core kfls_checker u_kfls_checker (.*);
